/* hw/rtl/d128_pkg.sv */
package d128_pkg;

    localparam int DIVIDEND_LIMBS = 2;
    localparam int LIMB_W = 64;
    localparam int NUM_W = LIMB_W * DIVIDEND_LIMBS;
    localparam int NUM_STAGES = NUM_W;

    typedef logic [LIMB_W-1:0] limb_t;
    typedef logic [NUM_W-1:0] num_t;

    typedef struct packed {
        num_t  num;
        limb_t rem;
    } step_t;

    function automatic step_t div_step(num_t num, limb_t rem, limb_t dv);
        logic [LIMB_W:0] trial;
        logic [LIMB_W:0] diff;
        step_t res;
        trial = {rem, num[NUM_W-1]};
        diff = trial - {1'b0, dv};
        if (trial >= {1'b0, dv})
        begin
            res.rem = diff[LIMB_W-1:0];
            res.num = {num[NUM_W-2:0], 1'b1};
        end
        else
        begin
            res.rem = trial[LIMB_W-1:0];
            res.num = {num[NUM_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

/* hw/rtl/divide_128_by_64.sv */
// unsigned divider: dividend (dividend_high:dividend_low) over divisor
// input channel: in_valid / in_stall with dividend_low, dividend_high, divisor
// output channel: out_valid / out_stall with quotient_low, quotient_high,
// remainder and divide_by_zero
// an item is taken at a clock edge where valid is high and stall is low
// one restoring subtract step per pipeline stage, one stage per quotient bit
// throughput: one item per cycle while the receiver does not stall, set by the stage-per-bit pipeline
// a zero divisor gives divide_by_zero high and all other fields zero
// in the one-limb build dividend_high is ignored and quotient_high is zero
// when the receiver stalls a waiting result, the whole pipeline holds and
// in_stall is raised; nothing is lost or repeated
// reset clears all stage valid bits; the output channel is then empty
module divide_128_by_64
    import d128_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] dividend_low,
    input  logic [63:0] dividend_high,
    input  logic [63:0] divisor,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] quotient_low,
    output logic [63:0] quotient_high,
    output logic [63:0] remainder,
    output logic        divide_by_zero
);

    logic  valid_reg [NUM_STAGES];
    num_t  num_reg [NUM_STAGES];
    limb_t rem_reg [NUM_STAGES];
    limb_t dv_reg [NUM_STAGES];
    logic  zero_reg [NUM_STAGES];

    num_t  num_next [NUM_STAGES];
    limb_t rem_next [NUM_STAGES];

    num_t  in_num;
    logic  advance;

    generate
        if (DIVIDEND_LIMBS >= 2)
        begin : g_two
            assign in_num = {dividend_high, dividend_low};
            assign quotient_high = zero_reg[NUM_STAGES-1] ? '0
                                 : num_reg[NUM_STAGES-1][NUM_W-1:LIMB_W];
        end
        else
        begin : g_one
            assign in_num = dividend_low;
            assign quotient_high = '0;
        end
    endgenerate

    assign advance = !(valid_reg[NUM_STAGES-1] && out_stall);
    assign in_stall = !advance;

    always_comb
    begin
        step_t st;
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            if (s == 0)
                st = div_step(in_num, '0, divisor);
            else
                st = div_step(num_reg[s-1], rem_reg[s-1], dv_reg[s-1]);
            num_next[s] = st.num;
            rem_next[s] = st.rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
                valid_reg[s] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < NUM_STAGES; s++)
                valid_reg[s] <= valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                num_reg[s] <= num_next[s];
                rem_reg[s] <= rem_next[s];
            end
            dv_reg[0] <= divisor;
            zero_reg[0] <= (divisor == '0);
            for (int s = 1; s < NUM_STAGES; s++)
            begin
                dv_reg[s] <= dv_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[NUM_STAGES-1];
    assign divide_by_zero = zero_reg[NUM_STAGES-1];
    assign quotient_low = zero_reg[NUM_STAGES-1] ? '0 : num_reg[NUM_STAGES-1][LIMB_W-1:0];
    assign remainder = zero_reg[NUM_STAGES-1] ? '0 : rem_reg[NUM_STAGES-1];

`ifndef SYNTH
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !divide_by_zero) |-> (remainder < dv_reg[NUM_STAGES-1]))
        else $error("remainder not below divisor");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && divide_by_zero) |->
        (quotient_low == '0 && quotient_high == '0 && remainder == '0))
        else $error("zero divisor result not cleared");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(dv_reg[NUM_STAGES-1])))
        else $error("pipeline moved during stall");
`endif

endmodule

/* dv/tb_top.sv */
module tb_top;
    import d128_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] dividend_low;
    logic [63:0] dividend_high;
    logic [63:0] divisor;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] quotient_low;
    logic [63:0] quotient_high;
    logic [63:0] remainder;
    logic        divide_by_zero;

    typedef struct packed {
        logic [63:0] q_lo;
        logic [63:0] q_hi;
        logic [63:0] rem;
        logic        dbz;
    } quot_t;

    quot_t quot_q[$];
    int    n_fail;
    int    n_sent;
    int    n_recv;
    int    n_zero;
    int    n_pow2;
    int    burst_left;
    int    gap_left;
    bit    stall_quiet;

    divide_128_by_64 uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .dividend_low(dividend_low),
        .dividend_high(dividend_high),
        .divisor(divisor),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .quotient_low(quotient_low),
        .quotient_high(quotient_high),
        .remainder(remainder),
        .divide_by_zero(divide_by_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("** divide_128_by_64: FAILED **");
        $finish;
    end

    // floor division of the (possibly one-limb) dividend
    function automatic quot_t divide_ref(logic [63:0] lo, logic [63:0] hi, logic [63:0] d);
        quot_t       res;
        logic [127:0] num;
        logic [127:0] q;
        num = {(DIVIDEND_LIMBS >= 2) ? hi : 64'd0, lo};
        res = '0;
        if (d == 64'd0)
            res.dbz = 1'b1;
        else
        begin
            q = num / {64'd0, d};
            res.q_lo = q[63:0];
            res.q_hi = q[127:64];
            res.rem = 64'(num % {64'd0, d});
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random divisor with a spread of bit lengths
    function automatic logic [63:0] rand_divisor();
        logic [63:0] d;
        int          sel;
        sel = $urandom_range(0, 9);
        d = rand64();
        if (sel < 4)
            d = d >> $urandom_range(0, 63);
        else if (sel == 4)
            d = 64'd1 << $urandom_range(0, 63);
        else if (sel == 5)
            d = 64'd0;
        else if (sel == 6)
            d = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
        return d;
    endfunction

    // sender bursts and gaps
    task automatic send_item(logic [63:0] lo, logic [63:0] hi, logic [63:0] d);
        if (burst_left == 0)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_left) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        in_valid <= 1'b1;
        dividend_low <= lo;
        dividend_high <= hi;
        divisor <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        quot_q.push_back(divide_ref(lo, hi, d));
        n_sent++;
        if (d == 64'd0)
            n_zero++;
        else if ((d & (d - 64'd1)) == 64'd0)
            n_pow2++;
    endtask

    task automatic finish_sending();
        in_valid <= 1'b0;
    endtask

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            quot_t exp_q;
            if (quot_q.size() == 0)
            begin
                $error("result with nothing expected");
                n_fail++;
            end
            else
            begin
                exp_q = quot_q.pop_front();
                n_recv++;
                if (quotient_low !== exp_q.q_lo)
                begin
                    $error("quotient_low exp %h got %h", exp_q.q_lo, quotient_low);
                    n_fail++;
                end
                if (quotient_high !== exp_q.q_hi)
                begin
                    $error("quotient_high exp %h got %h", exp_q.q_hi, quotient_high);
                    n_fail++;
                end
                if (remainder !== exp_q.rem)
                begin
                    $error("remainder exp %h got %h", exp_q.rem, remainder);
                    n_fail++;
                end
                if (divide_by_zero !== exp_q.dbz)
                begin
                    $error("divide_by_zero exp %b got %b", exp_q.dbz, divide_by_zero);
                    n_fail++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [63:0] ones;
        ones = 64'hFFFF_FFFF_FFFF_FFFF;
        send_item(64'd0, 64'd0, 64'd1);
        send_item(ones, ones, 64'd1);
        send_item(ones, ones, ones);
        send_item(ones, ones, 64'd0);
        send_item(64'd0, 64'd0, 64'd0);
        send_item(ones, ones, 64'd2);
        send_item(ones, ones, 64'h8000_0000_0000_0000);
        send_item(64'h1234_5678_9abc_def0, ones, 64'h8000_0000_0000_0001);
        send_item(ones, ones, 64'd3);
        send_item(64'd0, 64'd1, 64'd3);
        send_item(ones, 64'd0, 64'h0000_0001_0000_0000);
        send_item(ones, ones, 64'h0000_0001_0000_0001);
        send_item(64'd5, 64'd0, 64'd7);
        send_item(64'd0, ones, 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB);
        send_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_item(64'd0, 64'd0, ones);
        send_item(ones, 64'd0, 64'd10);
    endtask

    task automatic test_random();
        logic [63:0] hi;
        repeat (1730)
        begin
            hi = rand64();
            if ($urandom_range(0, 4) == 0)
                hi = hi >> $urandom_range(0, 63);
            send_item(rand64(), hi, rand_divisor());
        end
    endtask

    task automatic test_full_rate();
        stall_quiet = 1'b1;
        burst_left = 100;
        gap_left = 0;
        repeat (60)
            send_item(rand64(), rand64(), rand_divisor());
        stall_quiet = 1'b0;
    endtask

    initial
    begin
        int wait_cnt;
        rst_n = 1'b0;
        in_valid = 1'b0;
        dividend_low = '0;
        dividend_high = '0;
        divisor = '0;
        n_fail = 0;
        n_sent = 0;
        n_recv = 0;
        n_zero = 0;
        n_pow2 = 0;
        burst_left = 0;
        gap_left = 0;
        stall_quiet = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_full_rate();
        finish_sending();
        wait_cnt = 0;
        while (quot_q.size() != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        if (quot_q.size() != 0)
        begin
            $error("%0d results never arrived", quot_q.size());
            n_fail++;
        end
        repeat (200) @(posedge clk);
        $display("sent %0d divisions, checked %0d results", n_sent, n_recv);
        $display("zero divisors %0d, power-of-two divisors %0d", n_zero, n_pow2);
        if (n_fail == 0)
            $display("** divide_128_by_64: PASSED **");
        else
            $display("** divide_128_by_64: FAILED **");
        $finish;
    end
endmodule
